// ===== rtl/core/tmm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tmm_pkg
// Types and constants shared by the tile multiply-accumulate (transposed B).
// ----------------------------------------------------------------------------
package tmm_pkg;

    localparam int MAX_TILE = 8;
    localparam int IDX_W    = $clog2(MAX_TILE);
    localparam int ADDR_W   = 2 * IDX_W;
    localparam int DEPTH    = MAX_TILE * MAX_TILE;
    localparam int SIZE_W   = 4;
    localparam int VAL_W    = 32;
    localparam int FRAC_W   = 16;
    localparam int PROD_W   = 2 * VAL_W;
    // room for MAX_TILE full-scale products plus sign
    localparam int ACC_W    = PROD_W + $clog2(MAX_TILE) + 1;

    localparam logic [SIZE_W-1:0] TILE_SIZE_RST = SIZE_W'(MAX_TILE);

    typedef enum logic [1:0] {
        CMD_LOAD_A  = 2'd0,
        CMD_LOAD_BT = 2'd1,
        CMD_LOAD_C  = 2'd2,
        CMD_START   = 2'd3
    } tmm_cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } tmm_state_t;

    typedef struct packed {
        tmm_cmd_t                 cmd;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic signed [VAL_W-1:0]  value;
    } tmm_req_t;

    typedef struct packed {
        logic [IDX_W-1:0]         out_row;
        logic [IDX_W-1:0]         out_col;
        logic signed [VAL_W-1:0]  out_value;
        logic                     last;
    } tmm_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/core/tmm_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tmm_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/tile_matmul_transposed_b_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tile_matmul_transposed_b_top
// Tile multiply-accumulate C += A x Bt^T over signed Q16.16 tiles.
// ----------------------------------------------------------------------------
// Load beats (cmd load A / load Bt / load C) write one tile element each and
// produce no result. A start beat walks every (i,j) of the active n x n tile
// in row-major order (n = cfg_data, 0 acts as 1, above 8 acts as 8) and
// returns one result beat per element, last set on the final one. All
// products go through a single 32x32 multiplier fed by the A and Bt RAM read
// ports, one k per cycle; each element issues its n reads and then drains
// through the read, multiply and accumulate registers, and it also waits for
// the previous result beat to leave. The block takes no request beat while a
// tile is in progress. The sum over k is exact (68-bit accumulator),
// floor-shifted by 16, added to C[i][j] and saturated to 32 bits; the result
// is also written back into C. Tile entries have no reset value: read an
// entry only after loading it. Write cfg_data only while the block is idle.
// ----------------------------------------------------------------------------
module tile_matmul_transposed_b_top (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // request channel
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire tmm_pkg::tmm_req_t req,
    // result channel
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output tmm_pkg::tmm_rsp_t      rsp,
    // tile_size register
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [3:0]        cfg_data
);

    import tmm_pkg::*;

    // ---------------- state ----------------
    tmm_state_t          state_reg, state_next;
    logic [SIZE_W-1:0]   tile_size_reg;
    logic [IDX_W-1:0]    n_m1_reg;          // active size minus one
    logic [IDX_W-1:0]    i_reg, j_reg, k_reg;
    logic                rd_vld_reg;        // RAM read data valid this cycle
    logic                prod_vld_reg;      // product register valid
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                rsp_valid_reg;
    tmm_rsp_t            rsp_reg;

    // ---------------- control ----------------
    logic                req_fire;
    logic                start;
    logic                issue;       // read A[i][k], Bt[j][k] this cycle
    logic                c_rd;        // read C[i][j] with the first k
    logic                pipe_empty;
    logic                fire;        // finish element, load result register
    logic                last_elem;
    logic                k_last;
    logic [IDX_W-1:0]    n_m1_new;

    assign req_fire   = req_valid && req_ready;
    assign start      = req_fire && (req.cmd == CMD_START);
    assign k_last     = (k_reg == n_m1_reg);
    assign last_elem  = (i_reg == n_m1_reg) && (j_reg == n_m1_reg);
    assign pipe_empty = !rd_vld_reg && !prod_vld_reg;
    assign cfg_ready  = 1'b1;

    // clamp the configured size into 1..MAX_TILE, kept as size-1
    always_comb
    begin
        if (tile_size_reg == '0)
        begin
            n_m1_new = '0;
        end
        else if (tile_size_reg > SIZE_W'(MAX_TILE))
        begin
            n_m1_new = IDX_W'(MAX_TILE - 1);
        end
        else
        begin
            n_m1_new = IDX_W'(tile_size_reg - SIZE_W'(1));
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (k_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (fire)
                begin
                    state_next = last_elem ? ST_IDLE : ST_RUN;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        req_ready = 1'b0;
        issue     = 1'b0;
        fire      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
            end
            ST_RUN:
            begin
                issue = 1'b1;
            end
            ST_DRAIN:
            begin
                fire = pipe_empty && (!rsp_valid_reg || rsp_ready);
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

    assign c_rd = issue && (k_reg == '0);

    // ---------------- tile memories ----------------
    logic [VAL_W-1:0]   a_q, b_q, c_q;
    logic               a_we, b_we, c_we;
    logic [ADDR_W-1:0]  ld_addr, c_waddr;
    logic [VAL_W-1:0]   c_wdata;
    logic [VAL_W-1:0]   result;

    assign ld_addr = {req.row, req.col};
    assign a_we    = req_fire && (req.cmd == CMD_LOAD_A);
    assign b_we    = req_fire && (req.cmd == CMD_LOAD_BT);
    assign c_we    = (req_fire && (req.cmd == CMD_LOAD_C)) || fire;
    assign c_waddr = fire ? {i_reg, j_reg} : ld_addr;
    assign c_wdata = fire ? result : req.value;

    tmm_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_a_ram (
        .clk     (clk),
        .wr_en   (a_we),
        .wr_addr (ld_addr),
        .wr_data (req.value),
        .rd_en   (issue),
        .rd_addr ({i_reg, k_reg}),
        .rd_data (a_q)
    );

    tmm_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_bt_ram (
        .clk     (clk),
        .wr_en   (b_we),
        .wr_addr (ld_addr),
        .wr_data (req.value),
        .rd_en   (issue),
        .rd_addr ({j_reg, k_reg}),
        .rd_data (b_q)
    );

    tmm_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_c_ram (
        .clk     (clk),
        .wr_en   (c_we),
        .wr_addr (c_waddr),
        .wr_data (c_wdata),
        .rd_en   (c_rd),
        .rd_addr ({i_reg, j_reg}),
        .rd_data (c_q)
    );

    // ---------------- result: floor shift, add C, saturate ----------------
    logic signed [ACC_W-1:0] sum_w;
    logic                    in_range;

    assign sum_w    = (acc_reg >>> FRAC_W) + ACC_W'($signed(c_q));
    assign in_range = (&sum_w[ACC_W-1:VAL_W-1]) || !(|sum_w[ACC_W-1:VAL_W-1]);

    always_comb
    begin
        if (in_range)
        begin
            result = sum_w[VAL_W-1:0];
        end
        else if (sum_w[ACC_W-1])
        begin
            result = {1'b1, {(VAL_W-1){1'b0}}};
        end
        else
        begin
            result = {1'b0, {(VAL_W-1){1'b1}}};
        end
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tile_size_reg <= TILE_SIZE_RST;
            n_m1_reg      <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            rd_vld_reg    <= 1'b0;
            prod_vld_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_vld_reg   <= issue;
            prod_vld_reg <= rd_vld_reg;

            if (cfg_valid && cfg_ready)
            begin
                tile_size_reg <= cfg_data;
            end

            if (start)
            begin
                n_m1_reg <= n_m1_new;
                i_reg    <= '0;
                j_reg    <= '0;
                k_reg    <= '0;
            end
            else
            begin
                if (issue)
                begin
                    k_reg <= k_last ? '0 : k_reg + IDX_W'(1);
                end
                if (fire)
                begin
                    if (j_reg == n_m1_reg)
                    begin
                        j_reg <= '0;
                        i_reg <= i_reg + IDX_W'(1);
                    end
                    else
                    begin
                        j_reg <= j_reg + IDX_W'(1);
                    end
                end
            end

            if (fire)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk)
    begin
        if (rd_vld_reg)
        begin
            prod_reg <= $signed(a_q) * $signed(b_q);
        end

        // pipeline is empty when a new element starts issuing
        if (c_rd)
        begin
            acc_reg <= '0;
        end
        else if (prod_vld_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end

        if (fire)
        begin
            rsp_reg.out_row   <= i_reg;
            rsp_reg.out_col   <= j_reg;
            rsp_reg.out_value <= result;
            rsp_reg.last      <= last_elem;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // ---------------- assertions ----------------
    // a start always launches the k walk
    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> (state_reg == ST_RUN))
        else $error("start beat did not enter run");

    // a result is formed only after the MAC pipeline has drained
    a_fire_drained: assert property (@(posedge clk) disable iff (!rst_n)
        fire |-> (!rd_vld_reg && !prod_vld_reg && !issue))
        else $error("result formed with products in flight");

    // nothing left in flight once back to idle
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (!rd_vld_reg && !prod_vld_reg))
        else $error("MAC pipeline busy while idle");

    // the final element sits on the tile diagonal corner
    a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.last) |-> (rsp.out_row == rsp.out_col))
        else $error("last beat off the tile corner");

endmodule
`default_nettype wire
